// ----- rtl/core/pnms_pkg.sv -----
// Package for the prime numerator max select block.
// Holds the default width and the status bundle of the shared divider.
// No dependencies.
`default_nettype none

package pnms_pkg;

    // Default width of the numerator and denominator fields.
    localparam int NUM_WIDTH_DEF = 16;

    // Status of the shared remainder unit as seen by the sequencer.
    typedef struct packed {
        logic busy;
        logic done;
    } t_div_stat;

endpackage

`default_nettype wire

// ----- rtl/core/pnms_divider.sv -----
// Iterative restoring remainder unit, one dividend bit per cycle.
// Depends on pnms_pkg for the status bundle.
`default_nettype none

module pnms_divider #(
    parameter int NUM_W = pnms_pkg::NUM_WIDTH_DEF,
    parameter int DIV_W = (NUM_W + 1) / 2 + 1
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_start,
    input  wire logic [NUM_W-1:0]   i_dividend,
    input  wire logic [DIV_W-1:0]   i_divisor,
    output pnms_pkg::t_div_stat     o_stat,
    output logic      [DIV_W-1:0]   o_remainder
);

    localparam int CNT_W = $clog2(NUM_W + 1);

    logic             r_busy;
    logic             r_done;
    logic [CNT_W-1:0] r_count;
    logic [DIV_W-1:0] r_rem;
    logic [NUM_W-1:0] r_quo;
    logic [DIV_W-1:0] n_rem;
    logic [DIV_W:0]   trial;

    // Shift in the next dividend bit and subtract the divisor if it fits.
    always_comb begin
        trial = {r_rem, r_quo[NUM_W-1]};
        if (trial >= {1'b0, i_divisor}) begin
            n_rem = DIV_W'(trial - {1'b0, i_divisor});
        end else begin
            n_rem = DIV_W'(trial);
        end
    end

    // Sequencing of the bit steps; done pulses for one cycle at the end.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_done  <= 1'b0;
            r_count <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy  <= 1'b1;
                r_count <= CNT_W'(NUM_W);
                r_rem   <= '0;
                r_quo   <= i_dividend;
            end else if (r_busy) begin
                r_rem   <= n_rem;
                r_quo   <= {r_quo[NUM_W-2:0], 1'b0};
                r_count <= r_count - CNT_W'(1);
                if (r_count == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_stat.busy = r_busy;
    assign o_stat.done = r_done;
    assign o_remainder = r_rem;

endmodule

`default_nettype wire

// ----- rtl/core/prime_numerator_max_select.sv -----
// Every item takes a sequential primality test of its numerator magnitude by trial division
// with divisors 2, 3, ... while the divisor squared does not exceed the magnitude. Each trial
// divisor runs through the shared restoring remainder unit, which produces one bit per cycle.
// The input is not ready while an item is under test. The fraction with the largest prime
// magnitude is kept (the earlier one on a tie), and the item marked by tlast produces one
// result: the kept fraction with tuser set, or 0/1 with tuser clear.
// Depends on pnms_pkg and pnms_divider.
`default_nettype none

module prime_numerator_max_select #(
    parameter int NUM_WIDTH = pnms_pkg::NUM_WIDTH_DEF
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    // Input item.
    input  wire logic                                i_s_axis_tvalid,
    output logic                                     o_s_axis_tready,
    // tdata fields from bit 0: numerator, denominator, zero pad to bytes.
    input  wire logic [((2*NUM_WIDTH+7)/8)*8-1:0]    i_s_axis_tdata,
    // tlast: last_item.
    input  wire logic                                i_s_axis_tlast,
    // Result item.
    output logic                                     o_m_axis_tvalid,
    input  wire logic                                i_m_axis_tready,
    // tdata fields from bit 0: best_num, best_den, zero pad to bytes.
    output logic      [((2*NUM_WIDTH+7)/8)*8-1:0]    o_m_axis_tdata,
    // tuser fields from bit 0: found.
    output logic                                     o_m_axis_tuser
);

    localparam int TDATA_W = ((2 * NUM_WIDTH + 7) / 8) * 8;
    localparam int DIV_W   = (NUM_WIDTH + 1) / 2 + 1;
    localparam int SQ_W    = 2 * DIV_W;

    typedef enum logic [2:0] {
        S_IDLE,
        S_TEST,
        S_DIV,
        S_DECIDE,
        S_EMIT
    } t_state;

    t_state                  r_state;
    logic [NUM_WIDTH-1:0]    r_mag;
    logic [NUM_WIDTH-1:0]    r_num;
    logic [NUM_WIDTH-1:0]    r_den;
    logic                    r_last;
    logic                    r_prime;
    logic [DIV_W-1:0]        r_d;
    logic [SQ_W-1:0]         r_sq;
    logic                    r_div_start;
    logic                    r_have;
    logic [NUM_WIDTH-1:0]    r_kmag;
    logic [NUM_WIDTH-1:0]    r_knum;
    logic [NUM_WIDTH-1:0]    r_kden;
    logic                    r_out_valid;
    logic [NUM_WIDTH-1:0]    r_out_num;
    logic [NUM_WIDTH-1:0]    r_out_den;
    logic                    r_out_found;

    logic [NUM_WIDTH-1:0]    in_num;
    logic [NUM_WIDTH-1:0]    in_den;
    logic [NUM_WIDTH-1:0]    n_mag;
    logic                    out_free;

    pnms_pkg::t_div_stat     div_stat;
    logic [DIV_W-1:0]        div_rem;

    // Shared remainder unit.
    pnms_divider #(
        .NUM_W (NUM_WIDTH),
        .DIV_W (DIV_W)
    ) u_div (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (r_div_start),
        .i_dividend  (r_mag),
        .i_divisor   (r_d),
        .o_stat      (div_stat),
        .o_remainder (div_rem)
    );

    // Unpack the input item and take the numerator magnitude.
    always_comb begin
        in_num = i_s_axis_tdata[NUM_WIDTH-1:0];
        in_den = i_s_axis_tdata[2*NUM_WIDTH-1:NUM_WIDTH];
        if (in_num[NUM_WIDTH-1]) begin
            n_mag = ~in_num + NUM_WIDTH'(1);
        end else begin
            n_mag = in_num;
        end
    end

    assign out_free = !r_out_valid || i_m_axis_tready;

    // Sequencer, kept fraction and output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_div_start <= 1'b0;
            r_have      <= 1'b0;
            r_kmag      <= '0;
            r_knum      <= '0;
            r_kden      <= NUM_WIDTH'(1);
            r_out_valid <= 1'b0;
        end else begin
            r_div_start <= 1'b0;
            // A taken result frees the register unless the emit state reloads it.
            if (r_out_valid && i_m_axis_tready && r_state != S_EMIT) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_s_axis_tvalid) begin
                        r_mag   <= n_mag;
                        r_num   <= in_num;
                        r_den   <= in_den;
                        r_last  <= i_s_axis_tlast;
                        r_d     <= DIV_W'(2);
                        r_sq    <= SQ_W'(4);
                        r_state <= S_TEST;
                    end
                end
                S_TEST: begin
                    // Magnitudes below two are not prime; past the square root it is.
                    if (r_mag < NUM_WIDTH'(2)) begin
                        r_prime <= 1'b0;
                        r_state <= S_DECIDE;
                    end else if (r_sq > SQ_W'(r_mag)) begin
                        r_prime <= 1'b1;
                        r_state <= S_DECIDE;
                    end else begin
                        r_div_start <= 1'b1;
                        r_state     <= S_DIV;
                    end
                end
                S_DIV: begin
                    if (div_stat.done) begin
                        if (div_rem == '0) begin
                            r_prime <= 1'b0;
                            r_state <= S_DECIDE;
                        end else begin
                            r_d     <= r_d + DIV_W'(1);
                            r_sq    <= r_sq + SQ_W'({r_d, 1'b1});
                            r_state <= S_TEST;
                        end
                    end
                end
                S_DECIDE: begin
                    if (r_prime && (!r_have || r_mag > r_kmag)) begin
                        r_have <= 1'b1;
                        r_kmag <= r_mag;
                        r_knum <= r_num;
                        r_kden <= r_den;
                    end
                    r_state <= r_last ? S_EMIT : S_IDLE;
                end
                S_EMIT: begin
                    // Load the result once the output register is free, then clear.
                    if (out_free) begin
                        r_out_valid <= 1'b1;
                        r_out_num   <= r_have ? r_knum : '0;
                        r_out_den   <= r_have ? r_kden : NUM_WIDTH'(1);
                        r_out_found <= r_have;
                        r_have      <= 1'b0;
                        r_kmag      <= '0;
                        r_knum      <= '0;
                        r_kden      <= NUM_WIDTH'(1);
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_s_axis_tready = (r_state == S_IDLE);
    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = TDATA_W'({r_out_den, r_out_num});
    assign o_m_axis_tuser  = r_out_found;

    // The divider is only started when idle and from the division wait.
    a_start_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_div_start |-> (!div_stat.busy && r_state == S_DIV))
        else $error("divider started while busy or outside its wait state");

    // A remainder only completes while the sequencer waits for it.
    a_done_in_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_stat.done |-> r_state == S_DIV)
        else $error("divider finished outside the division wait");

    // A new result only appears after the emit state.
    a_emit_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !$past(r_out_valid && !i_m_axis_tready)) |->
            $past(r_state) == S_EMIT)
        else $error("result loaded outside the emit state");

    // With nothing kept the kept fraction holds its cleared values.
    a_kept_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_have |-> (r_kmag == '0 && r_knum == '0 && r_kden == NUM_WIDTH'(1)))
        else $error("kept fraction not cleared");

endmodule

`default_nettype wire

// ----- test/prime_numerator_max_select_tb.sv -----
// Self-checking testbench for prime_numerator_max_select: drives lists of fractions and
// checks each selected fraction against a scoreboard that redoes the trial division.
// Depends on pnms_pkg and the RTL of prime_numerator_max_select.
`timescale 1ns / 1ps

module prime_numerator_max_select_tb;

    localparam int NW = pnms_pkg::NUM_WIDTH_DEF;
    localparam int DW = ((2*NW+7)/8)*8;

    // Receiver hold-off used to back the block up, in clock cycles.
    localparam int HOLD_OFF_CYCLES = 4000;
    localparam int DRAIN_CYCLES = 4000;

    // Directed lists, packed as {last, denominator, numerator}.
    localparam logic [2*NW:0] DIRECTED_LISTS [19] = '{
        // No prime at all: zero and the largest denominator.
        {1'b1, 16'h7FFF, 16'h0000},
        // One, minus one, the most positive and the most negative numerator.
        {1'b0, 16'h8000, 16'h0001},
        {1'b0, 16'h0000, 16'hFFFF},
        {1'b0, 16'h0001, 16'h7FFF},
        {1'b1, 16'hFFFF, 16'h8000},
        // Two and minus two tie, squares are rejected, minus three wins.
        {1'b0, 16'h0003, 16'h0002},
        {1'b0, 16'h0005, 16'hFFFE},
        {1'b0, 16'h0007, 16'h0004},
        {1'b0, 16'h000B, 16'h0009},
        {1'b1, 16'h000D, 16'hFFFD},
        // Largest prime magnitude, positive first, then its negative as a tie.
        {1'b0, 16'h8000, 16'h7FED},
        {1'b0, 16'h7FFF, 16'h8013},
        {1'b1, 16'h0002, 16'h0019},
        // Negative largest prime kept over a smaller prime.
        {1'b0, 16'h0011, 16'h8013},
        {1'b1, 16'hFFFB, 16'h000D},
        // Tie between 13 and -13, then the square of 181 and of 11.
        {1'b0, 16'h0005, 16'h000D},
        {1'b0, 16'h0007, 16'hFFF3},
        {1'b0, 16'h0009, 16'h7FF9},
        {1'b1, 16'h0000, 16'h0079}
    };

    typedef struct packed {
        logic [NW-1:0] num;
        logic [NW-1:0] den;
        logic          found;
    } t_frac_result;

    // Tracks the kept fraction of the current list and the results still owed.
    class frac_scoreboard;
        logic          have_prime;
        int unsigned   kept_mag;
        logic [NW-1:0] kept_num;
        logic [NW-1:0] kept_den;
        t_frac_result  owed_q[$];
        int            errors;

        function new();
            clear_list();
            errors = 0;
        endfunction

        function void clear_list();
            have_prime = 1'b0;
            kept_mag   = 0;
            kept_num   = '0;
            kept_den   = NW'(1);
        endfunction

        function bit is_prime(int unsigned m);
            if (m < 2) return 1'b0;
            for (int unsigned d = 2; d * d <= m; d++) begin
                if (m % d == 0) return 1'b0;
            end
            return 1'b1;
        endfunction

        function int pending();
            return owed_q.size();
        endfunction

        // Update the kept fraction with one accepted item; the last item owes a result.
        function void note_input(logic [NW-1:0] num, logic [NW-1:0] den, logic last);
            logic [NW-1:0] neg;
            int unsigned   mag;
            t_frac_result  res;
            neg = -num;
            mag = 32'(num[NW-1] ? neg : num);
            if (is_prime(mag) && (!have_prime || mag > kept_mag)) begin
                have_prime = 1'b1;
                kept_mag   = mag;
                kept_num   = num;
                kept_den   = den;
            end
            if (last) begin
                res.num   = kept_num;
                res.den   = kept_den;
                res.found = have_prime;
                owed_q.push_back(res);
                clear_list();
            end
        endfunction

        // Compare one result item with the oldest owed result.
        function void check_result(logic [DW-1:0] data, logic user);
            t_frac_result got;
            t_frac_result want;
            got.num   = data[NW-1:0];
            got.den   = data[2*NW-1:NW];
            got.found = user;
            if (owed_q.size() == 0) begin
                $display("%0t: unexpected result num=%0d den=%0d found=%0b", $time,
                         $signed(got.num), $signed(got.den), got.found);
                errors++;
                return;
            end
            want = owed_q.pop_front();
            if (got.num !== want.num) begin
                $display("%0t: best_num expected %0d actual %0d", $time,
                         $signed(want.num), $signed(got.num));
                errors++;
            end
            if (got.den !== want.den) begin
                $display("%0t: best_den expected %0d actual %0d", $time,
                         $signed(want.den), $signed(got.den));
                errors++;
            end
            if (got.found !== want.found) begin
                $display("%0t: found expected %0b actual %0b", $time, want.found, got.found);
                errors++;
            end
        endfunction
    endclass

    logic          i_clk           = 1'b0;
    logic          i_rst_n         = 1'b0;
    logic          i_s_axis_tvalid = 1'b0;
    logic          o_s_axis_tready;
    // tdata fields from bit 0: numerator, denominator, zero pad to bytes.
    logic [DW-1:0] i_s_axis_tdata  = '0;
    // tlast: last_item.
    logic          i_s_axis_tlast  = 1'b0;
    logic          o_m_axis_tvalid;
    logic          i_m_axis_tready = 1'b0;
    // tdata fields from bit 0: best_num, best_den, zero pad to bytes.
    logic [DW-1:0] o_m_axis_tdata;
    // tuser fields from bit 0: found.
    logic          o_m_axis_tuser;

    frac_scoreboard sb = new();
    bit             hold_off_req = 1'b0;
    int             items_sent   = 0;

    prime_numerator_max_select DUT (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tlast  (i_s_axis_tlast),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser)
    );

    // Clock with a 2 ns period.
    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // Mostly no gap, sometimes a short one, rarely a long one.
    function automatic int pick_gap(bit steady);
        int unsigned r;
        r = $urandom_range(0, 99);
        if (steady || r < 55) return 0;
        if (r < 90) return $urandom_range(1, 4);
        return $urandom_range(15, 60);
    endfunction

    // Mostly small magnitudes keep the trial division short; a few use the full range.
    function automatic logic [NW-1:0] pick_numerator();
        int unsigned   r;
        logic [NW-1:0] v;
        r = $urandom_range(0, 99);
        if (r < 65) v = NW'($urandom_range(0, 300));
        else if (r < 90) v = NW'($urandom_range(0, 2500));
        else return NW'($urandom);
        if ($urandom_range(0, 1)) v = -v;
        return v;
    endfunction

    // Offer one item after an optional gap and wait until it is accepted.
    // Called right after a rising edge; valid stays high on return.
    task automatic send_item(input logic [NW-1:0] num, input logic [NW-1:0] den,
                             input logic last, input int gap);
        logic [DW-1:0] word;
        word = '0;
        word[NW-1:0]    = num;
        word[2*NW-1:NW] = den;
        if (gap > 0) begin
            i_s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= word;
        i_s_axis_tlast  <= last;
        do @(posedge i_clk); while (!o_s_axis_tready);
        sb.note_input(num, den, last);
        items_sent++;
    endtask

    // One list of random fractions; tiny lists use magnitudes that test fast.
    task automatic send_random_list(input bit tiny, input bit steady);
        int            len;
        logic [NW-1:0] num;
        len = $urandom_range(1, 6);
        for (int k = 0; k < len; k++) begin
            if (tiny) begin
                num = NW'($urandom_range(0, 40));
                if ($urandom_range(0, 1)) num = -num;
            end else begin
                num = pick_numerator();
            end
            send_item(num, NW'($urandom), k == len - 1, pick_gap(steady));
        end
    endtask

    // Stop offering items and wait until every owed result has arrived.
    task automatic drain_results();
        i_s_axis_tvalid <= 1'b0;
        do @(posedge i_clk); while (sb.pending() != 0);
    endtask

    // Result side: checks accepted results and stalls at random.
    initial begin : result_sink
        int   run_left;
        logic rdy_next;
        int unsigned r;
        run_left = 0;
        rdy_next = 1'b1;
        wait (i_rst_n === 1'b1);
        forever begin
            @(posedge i_clk);
            if (i_m_axis_tready && o_m_axis_tvalid)
                sb.check_result(o_m_axis_tdata, o_m_axis_tuser);
            if (hold_off_req) begin
                hold_off_req = 1'b0;
                rdy_next     = 1'b0;
                run_left     = HOLD_OFF_CYCLES;
            end else if (run_left > 0) begin
                run_left--;
            end else begin
                r        = $urandom_range(0, 99);
                rdy_next = (r % 4) != 0;
                if (r < 80) run_left = $urandom_range(0, 4);
                else if (r < 92) run_left = $urandom_range(10, 60);
                else begin
                    // A long stretch with the receiver always ready.
                    rdy_next = 1'b1;
                    run_left = $urandom_range(100, 400);
                end
            end
            i_m_axis_tready <= rdy_next;
        end
    end

    // Stimulus: directed lists, random lists, a back-pressure burst, more random lists.
    initial begin : stimulus
        logic [2*NW:0] d;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int k = 0; k < 19; k++) begin
            d = DIRECTED_LISTS[k];
            send_item(d[NW-1:0], d[2*NW-1:NW], d[2*NW], 0);
        end
        drain_results();

        while (items_sent < 100)
            send_random_list(1'b0, $urandom_range(0, 3) == 0);

        // Hold the receiver off while short lists keep coming, so the input stalls.
        hold_off_req = 1'b1;
        for (int k = 0; k < 8; k++)
            send_random_list(1'b1, 1'b1);
        drain_results();

        while (items_sent < 200)
            send_random_list(1'b0, $urandom_range(0, 3) == 0);
        drain_results();

        // Give the block time to show any result that should not come.
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // Timeout: ends the run as a mismatch if the stimulus does not finish first.
    initial begin : watchdog
        #8_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
